// File: rtl/core/emvt_pkg.sv
`default_nettype none

package emvt_pkg;

  localparam int unsigned COUNT_BITS     = 13;
  localparam int unsigned HISTORY_DEPTH  = 16;
  localparam int unsigned WARMUP_SAMPLES = 30;
  localparam int unsigned WARMUP_W       = $clog2(WARMUP_SAMPLES + 1);

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TURN_W  = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned PP_W    = 7;
  localparam int unsigned SHIFT_W = 4;

  // three registers at byte addresses 0, 4 and 8
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PAIR_CNT       = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_SCALE = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_FILTER_SHIFT   = REG_IDX_W'(2);

  localparam logic [PP_W-1:0]    PAIR_CNT_RST = PP_W'(4);
  localparam logic [DATA_W-1:0]  SCALE_RST    = DATA_W'(65536);
  localparam logic [SHIFT_W-1:0] SHIFT_RST    = SHIFT_W'(3);

  // 30/pi in Q4.28
  localparam logic [DATA_W-1:0] RPM_Q28  = 32'd2563369783;
  localparam int unsigned       RPM_FRAC = 28;
  localparam logic [PROD_W-1:0] RPM_ROUND = PROD_W'(1) << (RPM_FRAC - 1);

  localparam logic signed [COUNT_BITS:0] HALF_REV =
    (COUNT_BITS + 1)'(1) << (COUNT_BITS - 1);

  typedef struct packed {
    logic [PP_W-1:0]    pair_cnt;
    logic [DATA_W-1:0]  velocity_scale;
    logic [SHIFT_W-1:0] filter_shift;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/emvt_regs.sv
`default_nettype none

module emvt_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [emvt_pkg::ADDR_W-1:0]      paddr,
  input  logic [emvt_pkg::DATA_W-1:0]      pwdata,
  output logic [emvt_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  output emvt_pkg::cfg_t                   cfg_o
);

  logic [emvt_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  emvt_pkg::cfg_t                 cfg_q;

  assign reg_idx = paddr[emvt_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pair_cnt       <= emvt_pkg::PAIR_CNT_RST;
      cfg_q.velocity_scale <= emvt_pkg::SCALE_RST;
      cfg_q.filter_shift   <= emvt_pkg::SHIFT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        emvt_pkg::REG_PAIR_CNT: begin
          cfg_q.pair_cnt <= pwdata[emvt_pkg::PP_W-1:0];
        end
        emvt_pkg::REG_VELOCITY_SCALE: begin
          cfg_q.velocity_scale <= pwdata;
        end
        emvt_pkg::REG_FILTER_SHIFT: begin
          cfg_q.filter_shift <= pwdata[emvt_pkg::SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      emvt_pkg::REG_PAIR_CNT: begin
        prdata = emvt_pkg::DATA_W'(cfg_q.pair_cnt);
      end
      emvt_pkg::REG_VELOCITY_SCALE: begin
        prdata = cfg_q.velocity_scale;
      end
      emvt_pkg::REG_FILTER_SHIFT: begin
        prdata = emvt_pkg::DATA_W'(cfg_q.filter_shift);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/emvt_mul.sv
`default_nettype none

// shared unsigned multiplier, product registered
module emvt_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [emvt_pkg::DATA_W-1:0] op_a_i,
  input  logic [emvt_pkg::DATA_W-1:0] op_b_i,
  output logic [emvt_pkg::PROD_W-1:0] prod_o
);

  logic [emvt_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= emvt_pkg::PROD_W'(op_a_i) * emvt_pkg::PROD_W'(op_b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: rtl/core/encoder_multiturn_velocity_tracker_core.sv
// Multiturn absolute encoder tracker with windowed velocity estimate.
//
// Input channel: one angle_raw_i sample per transaction (in_valid_i / in_stall_o).
// Output channel: one result per input transaction (out_valid_o / out_stall_i),
// carrying single-turn and electrical counts, turns, multiturn position and
// four Q16.16 velocities plus the averaging status.
// Configuration: APB registers pair_cnt (0x0), velocity_scale (0x4) and
// filter_shift (0x8); write them only while no transaction is in flight.
//
// The result is loaded into the output register from the last step, S_DONE.
// A sequencer walks each sample through
// four products on the single shared 32x32 multiplier (electrical angle,
// velocity, rpm, electrical velocity) plus one saturation and one averaging
// step, and in_stall_o stays high for that whole walk.
// The output register holds a finished result while the receiver stalls, and
// the next sample is taken and processed meanwhile; its result waits in the
// last step until the output register is free.
// Reset clears the history, turns, warm-up and average, the output valid,
// and loads the register defaults (4, 65536, 3).
`default_nettype none

module encoder_multiturn_velocity_tracker_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [emvt_pkg::ADDR_W-1:0]          paddr,
  input  logic [emvt_pkg::DATA_W-1:0]          pwdata,
  output logic [emvt_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [emvt_pkg::ANGLE_W-1:0]         angle_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [emvt_pkg::COUNT_BITS-1:0]      mech_count_o,
  output logic [emvt_pkg::COUNT_BITS-1:0]      elec_count_o,
  output logic signed [emvt_pkg::TURN_W-1:0]   turn_count_o,
  output logic signed [emvt_pkg::DATA_W-1:0]   multiturn_count_o,
  output logic signed [emvt_pkg::DATA_W-1:0]   velocity_o,
  output logic signed [emvt_pkg::DATA_W-1:0]   velocity_rpm_o,
  output logic signed [emvt_pkg::DATA_W-1:0]   elec_velocity_o,
  output logic signed [emvt_pkg::DATA_W-1:0]   avg_velocity_o,
  output logic                                 avg_ready_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELEC,
    S_VEL,
    S_VSAT,
    S_RPM,
    S_EVEL,
    S_AVG,
    S_DONE
  } state_e;

  // clamp a magnitude to the signed 32-bit range of the given sign
  function automatic logic [emvt_pkg::DATA_W-1:0] clamp_mag(
    input logic                        neg,
    input logic [emvt_pkg::PROD_W-1:0] mag
  );
    logic [emvt_pkg::DATA_W-1:0] lim;
    lim = neg ? {1'b1, {(emvt_pkg::DATA_W-1){1'b0}}}
              : {1'b0, {(emvt_pkg::DATA_W-1){1'b1}}};
    if (mag > emvt_pkg::PROD_W'(lim)) begin
      return lim;
    end
    return mag[emvt_pkg::DATA_W-1:0];
  endfunction

  function automatic logic [emvt_pkg::DATA_W-1:0] apply_sign(
    input logic                        neg,
    input logic [emvt_pkg::DATA_W-1:0] mag
  );
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // saturate a two's complement value two bits wider than the output
  function automatic logic [emvt_pkg::DATA_W-1:0] sat_wide(
    input logic [emvt_pkg::DATA_W+1:0] v
  );
    logic [2:0] top;
    top = v[emvt_pkg::DATA_W+1:emvt_pkg::DATA_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[emvt_pkg::DATA_W-1:0];
    end
    return v[emvt_pkg::DATA_W+1] ? {1'b1, {(emvt_pkg::DATA_W-1){1'b0}}}
                                 : {1'b0, {(emvt_pkg::DATA_W-1){1'b1}}};
  endfunction

  localparam int unsigned CB = emvt_pkg::COUNT_BITS;
  localparam int unsigned DW = emvt_pkg::DATA_W;
  localparam int unsigned PW = emvt_pkg::PROD_W;
  localparam int unsigned HD = emvt_pkg::HISTORY_DEPTH;
  localparam int unsigned TW = emvt_pkg::TURN_W;
  localparam int unsigned WW = emvt_pkg::WARMUP_W;

  emvt_pkg::cfg_t cfg;

  state_e          state_q;
  logic [CB-1:0]   count_q;
  logic [CB-1:0]   prev_q;
  logic [TW-1:0]   turns_q;
  logic [DW-1:0]   hist_q [HD];
  logic            diff_neg_q;
  logic [DW:0]     diff_mag_q;
  logic [CB-1:0]   elec_q;
  logic [DW-1:0]   vel_q;
  logic [DW-1:0]   vel_mag_q;
  logic [DW-1:0]   rpm_q;
  logic [DW-1:0]   evel_q;
  logic [DW-1:0]   avg_q;
  logic [WW-1:0]   warm_q;
  logic            avg_on_q;

  logic            out_valid_q;
  logic [CB-1:0]   out_mech_q;
  logic [CB-1:0]   out_elec_q;
  logic [TW-1:0]   out_turn_q;
  logic [DW-1:0]   out_multi_q;
  logic [DW-1:0]   out_vel_q;
  logic [DW-1:0]   out_rpm_q;
  logic [DW-1:0]   out_evel_q;
  logic [DW-1:0]   out_avg_q;
  logic            out_avg_on_q;

  logic [CB-1:0]         count_in;
  logic signed [CB:0]    delta;
  logic [TW-1:0]         turns_d;
  logic [DW+1:0]         multi_wide;
  logic [DW-1:0]         multi;
  logic [DW:0]           diff;
  logic                  scale_big;
  logic [DW-1:0]         vel_mag_d;
  logic [PW-1:0]         rpm_sum;
  logic [PW-1:0]         rpm_mag;
  logic signed [DW:0]    avg_diff;
  logic signed [DW:0]    avg_step;
  logic [DW+1:0]         avg_sum;
  logic [WW-1:0]         warm_next;
  logic                  in_accept;
  logic                  out_free;

  logic          mul_en;
  logic [DW-1:0] mul_a;
  logic [DW-1:0] mul_b;
  logic [PW-1:0] prod;

  emvt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  emvt_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // turn unwrap and multiturn position
  always_comb begin
    count_in = angle_raw_i[emvt_pkg::ANGLE_W-1 -: CB];
    delta    = $signed({1'b0, count_in}) - $signed({1'b0, prev_q});
    turns_d  = turns_q;
    if (delta > emvt_pkg::HALF_REV) begin
      turns_d = turns_q - 1'b1;
    end else if (delta < -emvt_pkg::HALF_REV) begin
      turns_d = turns_q + 1'b1;
    end
    multi_wide = {{(DW + 2 - TW - CB){turns_d[TW-1]}}, turns_d, count_in};
    multi      = sat_wide(multi_wide);
  end

  // window difference, newest minus oldest
  assign diff = {hist_q[0][DW-1], hist_q[0]} - {hist_q[HD-1][DW-1], hist_q[HD-1]};

  // a magnitude beyond 32 bits saturates unless the scale is zero
  assign scale_big = diff_mag_q[DW] && (cfg.velocity_scale != '0);
  assign vel_mag_d = clamp_mag(diff_neg_q, scale_big ? {PW{1'b1}} : prod);

  assign rpm_sum = prod + emvt_pkg::RPM_ROUND;
  assign rpm_mag = PW'(rpm_sum[PW-1:emvt_pkg::RPM_FRAC]);

  assign avg_diff  = {vel_q[DW-1], vel_q} - {avg_q[DW-1], avg_q};
  assign avg_step  = avg_diff >>> cfg.filter_shift;
  assign avg_sum   = {avg_step[DW], avg_step} + {{2{avg_q[DW-1]}}, avg_q};
  assign warm_next = warm_q + 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ELEC: begin
        mul_a = DW'(count_q);
        mul_b = DW'(cfg.pair_cnt);
      end
      S_VEL: begin
        mul_a = diff_mag_q[DW-1:0];
        mul_b = cfg.velocity_scale;
      end
      S_RPM: begin
        mul_a = vel_mag_q;
        mul_b = emvt_pkg::RPM_Q28;
      end
      S_EVEL: begin
        mul_a = vel_mag_q;
        mul_b = DW'(cfg.pair_cnt);
      end
      default: begin
      end
    endcase
  end

  assign mul_en = (state_q == S_ELEC) || (state_q == S_VEL) ||
                  (state_q == S_RPM) || (state_q == S_EVEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      prev_q       <= '0;
      turns_q      <= '0;
      for (int i = 0; i < HD; i++) begin
        hist_q[i] <= '0;
      end
      diff_neg_q   <= 1'b0;
      diff_mag_q   <= '0;
      elec_q       <= '0;
      vel_q        <= '0;
      vel_mag_q    <= '0;
      rpm_q        <= '0;
      evel_q       <= '0;
      avg_q        <= '0;
      warm_q       <= '0;
      avg_on_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_mech_q   <= '0;
      out_elec_q   <= '0;
      out_turn_q   <= '0;
      out_multi_q  <= '0;
      out_vel_q    <= '0;
      out_rpm_q    <= '0;
      out_evel_q   <= '0;
      out_avg_q    <= '0;
      out_avg_on_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            count_q   <= count_in;
            prev_q    <= count_in;
            turns_q   <= turns_d;
            hist_q[0] <= multi;
            for (int i = 1; i < HD; i++) begin
              hist_q[i] <= hist_q[i-1];
            end
            state_q <= S_ELEC;
          end
        end
        S_ELEC: begin
          diff_neg_q <= diff[DW];
          diff_mag_q <= diff[DW] ? (~diff + 1'b1) : diff;
          state_q    <= S_VEL;
        end
        S_VEL: begin
          elec_q  <= prod[CB-1:0];
          state_q <= S_VSAT;
        end
        S_VSAT: begin
          vel_mag_q <= vel_mag_d;
          vel_q     <= apply_sign(diff_neg_q, vel_mag_d);
          state_q   <= S_RPM;
        end
        S_RPM: begin
          state_q <= S_EVEL;
        end
        S_EVEL: begin
          rpm_q   <= apply_sign(vel_q[DW-1], clamp_mag(vel_q[DW-1], rpm_mag));
          state_q <= S_AVG;
        end
        S_AVG: begin
          evel_q <= apply_sign(vel_q[DW-1], clamp_mag(vel_q[DW-1], prod));
          if (!avg_on_q) begin
            warm_q <= warm_next;
            avg_q  <= '0;
            if (warm_next >= WW'(emvt_pkg::WARMUP_SAMPLES)) begin
              avg_on_q <= 1'b1;
            end
          end else begin
            avg_q <= sat_wide(avg_sum);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_mech_q   <= count_q;
            out_elec_q   <= elec_q;
            out_turn_q   <= turns_q;
            out_multi_q  <= hist_q[0];
            out_vel_q    <= vel_q;
            out_rpm_q    <= rpm_q;
            out_evel_q   <= evel_q;
            out_avg_q    <= avg_q;
            out_avg_on_q <= avg_on_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mech_count_o      = out_mech_q;
  assign elec_count_o      = out_elec_q;
  assign turn_count_o      = out_turn_q;
  assign multiturn_count_o = out_multi_q;
  assign velocity_o        = out_vel_q;
  assign velocity_rpm_o    = out_rpm_q;
  assign elec_velocity_o   = out_evel_q;
  assign avg_velocity_o    = out_avg_q;
  assign avg_ready_o       = out_avg_on_q;

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block not busy after an input transaction");

  a_turns_only_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(turns_q))
    else $error("turn counter changed without an input transaction");

  a_avg_stays_on : assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_on_q |=> avg_on_q)
    else $error("averaging switched off after warm-up");

  a_avg_zero_in_warmup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !avg_ready_o) |-> (avg_velocity_o == '0))
    else $error("average velocity nonzero during warm-up");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_o && !in_stall_o))
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
